// File: hdl/priority_periodic_task_dispatcher_unit_macros.svh
// ----------------------------------------------------------------------------
// Dispatcher assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PERIODIC_TASK_DISPATCHER_UNIT_MACROS_SVH
`define PRIORITY_PERIODIC_TASK_DISPATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPTD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define PPTD_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PPTD_ASSERT(label, clk, rst, prop)
`define PPTD_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: hdl/pptd_pkg.sv
// ----------------------------------------------------------------------------
// Dispatcher package
// Shared widths, command codes, slot states and control structs.
// ----------------------------------------------------------------------------
package pptd_pkg;
  localparam int SlotBits = 4;
  localparam int Slots = 16;
  localparam int TimeBits = 32;
  localparam int CntBits = 5;
  localparam logic [TimeBits-1:0] TimeMax = '1;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_SUSPEND = 3'd2, CMD_RESUME = 3'd3,
    CMD_TICK = 3'd4, CMD_DISPATCH = 3'd5, CMD_COMPLETE = 3'd6, CMD_QUERY = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_SUSPENDED = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_clear;
    logic scan_step;
    logic commit_pick;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic is_dispatch;
    logic scan_last;
  } stat_t;
endpackage

// File: hdl/pptd_if.sv
// ----------------------------------------------------------------------------
// Dispatcher channel interfaces
// Valid/ready channels carrying command and result payloads.
// ----------------------------------------------------------------------------
interface pptd_cmd_if import pptd_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] command;
  logic [3:0] slot;
  logic [2:0] priority_req;
  logic [15:0] period;
  logic fault;
  modport source (output valid, command, slot, priority_req, period, fault, input ready);
  modport sink (input valid, command, slot, priority_req, period, fault, output ready);
endinterface

interface pptd_res_if import pptd_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic ok;
  logic [3:0] chosen_slot;
  logic [2:0] slot_state;
  logic [2:0] slot_priority;
  logic [31:0] run_count;
  logic [31:0] busy_total;
  logic [31:0] last_start;
  logic [4:0] total_tasks;
  logic [4:0] active_tasks;
  modport source (output valid, ok, chosen_slot, slot_state, slot_priority, run_count,
    busy_total, last_start, total_tasks, active_tasks, input ready);
  modport sink (input valid, ok, chosen_slot, slot_state, slot_priority, run_count,
    busy_total, last_start, total_tasks, active_tasks, output ready);
endinterface

// File: hdl/pptd_ctrl.sv
// ----------------------------------------------------------------------------
// Dispatcher controller
// Sequences command capture, slot scan, execution and result hand-off.
// ----------------------------------------------------------------------------
module pptd_ctrl import pptd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_valid,
  input  logic out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_EXEC = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          ctrl.scan_clear = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.is_dispatch) state_next = S_EXEC;
        else begin
          ctrl.scan_step = 1'b1;
          if (stat.scan_last) state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        ctrl.commit_pick = stat.is_dispatch;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          ctrl.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: hdl/pptd_dp.sv
// ----------------------------------------------------------------------------
// Dispatcher datapath
// Slot table, time counter, best-slot scan and result register.
// ----------------------------------------------------------------------------
module pptd_dp import pptd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  ctrl_t ctrl,
  output stat_t stat,
  input  logic [2:0] command,
  input  logic [3:0] slot,
  input  logic [2:0] priority_req,
  input  logic [15:0] period,
  input  logic fault,
  input  logic out_ready,
  output logic out_valid,
  output logic ok,
  output logic [3:0] chosen_slot,
  output logic [2:0] slot_state,
  output logic [2:0] slot_priority,
  output logic [31:0] run_count,
  output logic [31:0] busy_total,
  output logic [31:0] last_start,
  output logic [4:0] total_tasks,
  output logic [4:0] active_tasks
);
  logic [2:0] st [Slots];
  logic [2:0] pr [Slots];
  logic [15:0] per [Slots];
  logic [TimeBits-1:0] due [Slots];
  logic [TimeBits-1:0] lst [Slots];
  logic [31:0] runs [Slots];
  logic [31:0] busy [Slots];
  logic [15:0] ord [Slots];
  logic [TimeBits-1:0] time_now;
  logic [15:0] add_seq;

  cmd_t c_cmd;
  logic [3:0] c_slot;
  logic [2:0] c_prio;
  logic [15:0] c_per;
  logic c_fault;

  logic [SlotBits:0] scan_idx;
  logic found;
  logic [3:0] best;

  logic r_ok;
  logic [3:0] r_chosen;
  logic [2:0] r_state, r_prio;
  logic [31:0] r_runs, r_busy, r_last;

  logic [SlotBits-1:0] si;
  logic cand, beat;
  assign si = scan_idx[SlotBits-1:0];
  assign stat.is_dispatch = (c_cmd == CMD_DISPATCH);
  assign stat.scan_last = (scan_idx == 5'(Slots - 1));

  always_comb begin
    cand = (st[si] == ST_READY) && ((per[si] == '0) || (time_now >= due[si]));
    if (pr[si] != pr[best]) beat = pr[si] > pr[best];
    else if (lst[si] != lst[best]) beat = lst[si] < lst[best];
    else beat = ord[si] < ord[best];
  end

  logic [TimeBits-1:0] el;
  logic [32:0] busy_sum;
  logic [TimeBits:0] due_sum;
  always_comb begin
    el = (time_now >= lst[c_slot]) ? time_now - lst[c_slot] : '0;
    busy_sum = {1'b0, busy[c_slot]} + {1'b0, el};
    due_sum = {1'b0, time_now} + {{(TimeBits-15){1'b0}}, per[c_slot]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c_cmd <= cmd_t'(command);
      c_slot <= slot;
      c_prio <= priority_req;
      c_per <= period;
      c_fault <= fault;
    end
    if (ctrl.scan_clear) begin
      scan_idx <= '0;
      found <= 1'b0;
      best <= '0;
    end else if (ctrl.scan_step) begin
      scan_idx <= scan_idx + 5'd1;
      if (cand && (!found || beat)) begin
        best <= si;
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Slots; i++) begin
        st[i] <= ST_EMPTY; pr[i] <= '0; per[i] <= '0; due[i] <= '0;
        lst[i] <= '0; runs[i] <= '0; busy[i] <= '0; ord[i] <= '0;
      end
      time_now <= '0;
      add_seq <= '0;
    end else if (ctrl.exec) begin
      r_ok <= 1'b0; r_chosen <= '0; r_state <= '0; r_prio <= '0;
      r_runs <= '0; r_busy <= '0; r_last <= '0;
      unique case (c_cmd)
        CMD_ADD: if (st[c_slot] == ST_EMPTY) begin
          st[c_slot] <= ST_READY; pr[c_slot] <= c_prio; per[c_slot] <= c_per;
          due[c_slot] <= time_now; lst[c_slot] <= time_now;
          runs[c_slot] <= '0; busy[c_slot] <= '0; ord[c_slot] <= add_seq;
          if (add_seq != 16'hFFFF) add_seq <= add_seq + 16'd1;
          r_ok <= 1'b1;
        end
        CMD_REMOVE: if (st[c_slot] != ST_EMPTY) begin
          st[c_slot] <= ST_EMPTY; pr[c_slot] <= '0; per[c_slot] <= '0;
          due[c_slot] <= '0; lst[c_slot] <= '0; runs[c_slot] <= '0;
          busy[c_slot] <= '0; ord[c_slot] <= '0;
          r_ok <= 1'b1;
        end
        CMD_SUSPEND: if (st[c_slot] != ST_EMPTY) begin
          st[c_slot] <= ST_SUSPENDED; r_ok <= 1'b1;
        end
        CMD_RESUME: if (st[c_slot] != ST_EMPTY) begin
          st[c_slot] <= ST_READY; r_ok <= 1'b1;
        end
        CMD_TICK: begin
          if (time_now != TimeMax) time_now <= time_now + 1'b1;
          r_ok <= 1'b1;
        end
        CMD_DISPATCH: if (found && ctrl.commit_pick) begin
          st[best] <= ST_RUNNING; lst[best] <= time_now;
          r_ok <= 1'b1; r_chosen <= best;
        end
        CMD_COMPLETE: if (st[c_slot] == ST_RUNNING) begin
          if (c_fault) st[c_slot] <= ST_TERMINATED;
          else begin
            if (runs[c_slot] != 32'hFFFF_FFFF) runs[c_slot] <= runs[c_slot] + 32'd1;
            busy[c_slot] <= busy_sum[32] ? 32'hFFFF_FFFF : busy_sum[31:0];
            st[c_slot] <= ST_READY;
            if (per[c_slot] != '0) due[c_slot] <= due_sum[TimeBits] ? TimeMax : due_sum[TimeBits-1:0];
          end
          r_ok <= 1'b1;
        end
        CMD_QUERY: if (st[c_slot] != ST_EMPTY) begin
          r_ok <= 1'b1; r_state <= st[c_slot]; r_prio <= pr[c_slot];
          r_runs <= runs[c_slot]; r_busy <= busy[c_slot]; r_last <= lst[c_slot];
        end
        default: ;
      endcase
    end
  end

  logic [4:0] tot, act;
  always_comb begin
    tot = '0; act = '0;
    for (int i = 0; i < Slots; i++) begin
      tot = tot + 5'(st[i] != ST_EMPTY);
      act = act + 5'((st[i] == ST_READY) || (st[i] == ST_RUNNING));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctrl.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (ctrl.out_load) begin
      ok <= r_ok; chosen_slot <= r_chosen; slot_state <= r_state; slot_priority <= r_prio;
      run_count <= r_runs; busy_total <= r_busy; last_start <= r_last;
      total_tasks <= tot; active_tasks <= act;
    end
  end
endmodule

// File: hdl/priority_periodic_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// Priority periodic task dispatcher
// Fixed-priority task table with least-recently-started tie-break.
// ----------------------------------------------------------------------------
// Channel | Role | Payload
// cmd     | sink   | command, slot, priority_req, period, fault
// res     | source | ok, chosen_slot, slot state and statistics, task counts
// A dispatch scans the slot table one slot per cycle over sixteen slots before it executes.
// Other commands pass the scan state without stepping. One command is in flight at a time.
// Reset is synchronous and empties all slots. The result register holds
// a transaction until taken; a stalled result delays the next command.
`include "priority_periodic_task_dispatcher_unit_macros.svh"
module priority_periodic_task_dispatcher_unit import pptd_pkg::*; (
  input logic clk,
  input logic rst,
  pptd_cmd_if.sink cmd,
  pptd_res_if.source res
);
  ctrl_t ctrl;
  stat_t stat;

  pptd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(cmd.valid), .in_ready(cmd.ready),
    .out_valid(res.valid), .out_ready(res.ready), .stat(stat), .ctrl(ctrl)
  );

  pptd_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .command(cmd.command), .slot(cmd.slot), .priority_req(cmd.priority_req),
    .period(cmd.period), .fault(cmd.fault), .out_ready(res.ready),
    .out_valid(res.valid), .ok(res.ok), .chosen_slot(res.chosen_slot),
    .slot_state(res.slot_state), .slot_priority(res.slot_priority),
    .run_count(res.run_count), .busy_total(res.busy_total),
    .last_start(res.last_start), .total_tasks(res.total_tasks),
    .active_tasks(res.active_tasks)
  );

  `PPTD_ASSERT(a_no_accept_in_flight, clk, rst, (cmd.valid && cmd.ready) |=> !cmd.ready)
  `PPTD_ASSERT(a_counts_order, clk, rst, res.valid |-> (res.active_tasks <= res.total_tasks))
  `PPTD_ASSERT(a_chosen_ok, clk, rst, (res.valid && !res.ok) |-> (res.chosen_slot == 4'd0))
endmodule
